FILE: hdl/assert_macros.svh
// Assertion macros for the RTL of the positional list engine (used by positional_list_engine_core).
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, checked on every rising clk edge outside reset.
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in this cycle implies the property in the next cycle.
`define PLE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine_core.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed port widths
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 8;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_GET     = 3'd1,
    OP_DELETE  = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_REVERSE = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE,
    CELL_LOAD_BUS,
    CELL_SHIFT_BUS
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       pos;
    logic [HANDLE_BITS-1:0] hdl;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/ple_cell.sv
// One cell of the list row: holds one entry and one slot of the read bus.
// Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell (
  input  wire logic                            clk,
  input  wire ple_pkg::cell_cmd_t              cmd,
  input  wire logic [ple_pkg::IDX_W-1:0]       idx,
  input  wire logic [ple_pkg::HANDLE_BITS-1:0] below_data,
  input  wire logic [ple_pkg::HANDLE_BITS-1:0] above_data,
  input  wire logic [ple_pkg::HANDLE_BITS-1:0] head_data,
  input  wire logic [ple_pkg::HANDLE_BITS-1:0] above_bus,
  output logic      [ple_pkg::HANDLE_BITS-1:0] data,
  output logic      [ple_pkg::HANDLE_BITS-1:0] bus
);

  logic [ple_pkg::HANDLE_BITS-1:0] data_r, data_nxt;
  logic [ple_pkg::HANDLE_BITS-1:0] bus_r, bus_nxt;

  always_comb begin
    data_nxt = data_r;
    bus_nxt  = bus_r;
    case (cmd.op)
      ple_pkg::CELL_HOLD: begin
      end
      ple_pkg::CELL_INSERT: begin
        // open a gap at pos, entries above move up one
        if (idx > cmd.pos) begin
          data_nxt = below_data;
        end else if (idx == cmd.pos) begin
          data_nxt = cmd.hdl;
        end
      end
      ple_pkg::CELL_REMOVE: begin
        if (idx >= cmd.pos) begin
          data_nxt = above_data;
        end
      end
      ple_pkg::CELL_ROTATE: begin
        // head entry moves to pos, cells below it move down one
        if (idx < cmd.pos) begin
          data_nxt = above_data;
        end else if (idx == cmd.pos) begin
          data_nxt = head_data;
        end
      end
      ple_pkg::CELL_LOAD_BUS: begin
        bus_nxt = (idx == cmd.pos) ? data_r : '0;
      end
      ple_pkg::CELL_SHIFT_BUS: begin
        bus_nxt = above_bus;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    bus_r  <= bus_nxt;
  end

  assign data = data_r;
  assign bus  = bus_r;

endmodule

`default_nettype wire

FILE: hdl/positional_list_engine_core.sv
// Positional list engine: a row of ple_cell entries plus the sequencer that drives it.
// Depends on ple_pkg, ple_cell and assert_macros.svh.
// Insert, clear, refusals, reverse of up to one entry: strobe in the cycle after accept.
// Get/delete at position p: strobe once the read bus has walked down the row from cell p to cell 0.
// Reverse of n > 1 entries: strobe after the n-1 rotate steps of the row.
// busy drops with the strobe, so the next beat may start then; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the list and idles the sequencer; entries keep junk.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module positional_list_engine_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ple_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [ple_pkg::POS_W-1:0]    in_position,
  input  wire logic [ple_pkg::HANDLE_W-1:0] in_handle_in,
  // result channel, one beat per command
  output logic                              out_valid,
  output logic                              out_ok,
  output logic      [ple_pkg::HANDLE_W-1:0] out_handle_out,
  output logic      [ple_pkg::COUNT_W-1:0]  out_count
);

  localparam int CAPACITY = ple_pkg::CAPACITY;
  localparam int HB       = ple_pkg::HANDLE_BITS;
  localparam int IDX_W    = ple_pkg::IDX_W;
  localparam int CNT_W    = ple_pkg::CNT_W;
  // compare width wide enough for both position and count
  localparam int CMP_W    = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,  // read bus walking toward cell 0
    S_REV    // rotate steps of a reverse
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [IDX_W-1:0]             step_r, step_nxt;   // read countdown, or rotate target
  logic [IDX_W-1:0]             pos_r, pos_nxt;     // delete position
  logic                         del_r, del_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_ok_r, out_ok_nxt;
  logic [ple_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [ple_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  ple_pkg::cell_cmd_t cmd;

  logic [HB-1:0] cell_data [CAPACITY];
  logic [HB-1:0] cell_bus  [CAPACITY];

  logic             in_acc;
  logic             in_range;
  logic             full;
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic [IDX_W-1:0] ins_pos;

  assign busy   = (state_r != S_IDLE);
  assign in_acc = start && !busy;

  assign pos_w    = CMP_W'(in_position);
  assign cnt_w    = CMP_W'(count_r);
  assign in_range = (pos_w < cnt_w);
  assign full     = (count_r == CNT_W'(CAPACITY));
  // past the end means append; the list is not full here so count fits an index
  assign ins_pos  = (pos_w > cnt_w) ? IDX_W'(count_r) : IDX_W'(in_position);

  // ---------------------------------------------------------------------------
  // Sequencer: decodes the accepted beat, drives the row and forms the result.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    pos_nxt        = pos_r;
    del_nxt        = del_r;
    out_valid_nxt  = 1'b0;
    out_ok_nxt     = out_ok_r;
    out_handle_nxt = out_handle_r;
    out_count_nxt  = out_count_r;
    cmd.op         = ple_pkg::CELL_HOLD;
    cmd.pos        = '0;
    cmd.hdl        = HB'(in_handle_in);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // default: immediate beat with a zero handle
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = 1'b0;
          out_handle_nxt = '0;
          case (in_opcode)
            ple_pkg::OP_INSERT: begin
              if (!full) begin
                cmd.op     = ple_pkg::CELL_INSERT;
                cmd.pos    = ins_pos;
                count_nxt  = count_r + 1'b1;
                out_ok_nxt = 1'b1;
              end
            end
            ple_pkg::OP_GET, ple_pkg::OP_DELETE: begin
              if (in_range) begin
                // park the addressed entry on the read bus, then walk it down
                cmd.op        = ple_pkg::CELL_LOAD_BUS;
                cmd.pos       = IDX_W'(in_position);
                step_nxt      = IDX_W'(in_position);
                pos_nxt       = IDX_W'(in_position);
                del_nxt       = (in_opcode == ple_pkg::OP_DELETE);
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            ple_pkg::OP_CLEAR: begin
              count_nxt  = '0;
              out_ok_nxt = 1'b1;
            end
            ple_pkg::OP_REVERSE: begin
              out_ok_nxt = 1'b1;
              if (count_r > CNT_W'(1)) begin
                step_nxt      = IDX_W'(count_r - 1'b1);
                out_valid_nxt = 1'b0;
                state_nxt     = S_REV;
              end
            end
            default: begin
            end
          endcase
          out_count_nxt = ple_pkg::COUNT_W'(count_nxt);
        end
      end

      S_READ: begin
        if (step_r == '0) begin
          // wanted entry sits in cell 0's bus slot
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = 1'b1;
          out_handle_nxt = ple_pkg::HANDLE_W'(cell_bus[0]);
          if (del_r) begin
            cmd.op    = ple_pkg::CELL_REMOVE;
            cmd.pos   = pos_r;
            count_nxt = count_r - 1'b1;
          end
          out_count_nxt = ple_pkg::COUNT_W'(count_nxt);
          state_nxt     = S_IDLE;
        end else begin
          cmd.op   = ple_pkg::CELL_SHIFT_BUS;
          step_nxt = step_r - 1'b1;
        end
      end

      S_REV: begin
        // head moves to step_r; after steps n-1 .. 1 the order is flipped
        cmd.op  = ple_pkg::CELL_ROTATE;
        cmd.pos = step_r;
        if (step_r == IDX_W'(1)) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = 1'b1;
          out_handle_nxt = '0;
          out_count_nxt  = ple_pkg::COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      step_r       <= step_nxt;
      pos_r        <= pos_nxt;
      del_r        <= del_nxt;
      out_valid_r  <= out_valid_nxt;
      out_ok_r     <= out_ok_nxt;
      out_handle_r <= out_handle_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_handle_out = out_handle_r;
  assign out_count      = out_count_r;

  // ---------------------------------------------------------------------------
  // Row of cells; each talks only to its neighbours and to the head cell.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [HB-1:0] below_d, above_d, above_b;

    if (i == 0) begin : g_first
      assign below_d = '0;
    end else begin : g_mid_lo
      assign below_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign above_d = '0;
      assign above_b = '0;
    end else begin : g_mid_hi
      assign above_d = cell_data[i+1];
      assign above_b = cell_bus[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(i)),
      .below_data (below_d),
      .above_data (above_d),
      .head_data  (cell_data[0]),
      .above_bus  (above_b),
      .data       (cell_data[i]),
      .bus        (cell_bus[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PLE_ASSERT_NEXT(a_full_refused, in_acc && (in_opcode == ple_pkg::OP_INSERT) && full, out_valid_r && !out_ok_r && $stable(count_r), "insert into full list not refused")
  `PLE_ASSERT_NEXT(a_clear_empties, in_acc && (in_opcode == ple_pkg::OP_CLEAR), out_valid_r && out_ok_r && (count_r == '0), "clear did not empty the list")
  `PLE_ASSERT(a_beat_when_idle, out_valid_r |-> (state_r == S_IDLE), "result beat while sequencer busy")
  `PLE_ASSERT(a_refusal_zero, (out_valid_r && !out_ok_r) |-> (out_handle_r == '0), "refusal carries a handle")
  `PLE_ASSERT_NEXT(a_rev_keeps_count, state_r == S_REV, $stable(count_r), "count changed during reverse")

endmodule

`default_nettype wire
